/* rtl/sid_pkg.sv */
// shared types and constants for the signed integer divider
`timescale 1ns / 1ps

package sid_pkg;

    // operand and quotient width
    localparam int DIV_WIDTH = 32;

    // cycles from the accepting edge to the edge that takes the result
    localparam int DIV_LATENCY = DIV_WIDTH + 2;

    // special operand and result codes
    localparam logic [DIV_WIDTH-1:0] DIV_MOST_NEG = {1'b1, {(DIV_WIDTH-1){1'b0}}};
    localparam logic [DIV_WIDTH-1:0] DIV_MOST_POS = {1'b0, {(DIV_WIDTH-1){1'b1}}};
    localparam logic [DIV_WIDTH-1:0] DIV_ALL_ONES = {DIV_WIDTH{1'b1}};

    // one division request
    typedef struct packed {
        logic signed [DIV_WIDTH-1:0] numerator;
        logic signed [DIV_WIDTH-1:0] denominator;
    } div_in_t;

    // one division result
    typedef struct packed {
        logic signed [DIV_WIDTH-1:0] quotient;
        logic                        zero_divisor;
        logic                        overflowed;
    } div_out_t;

    // side information that rides along the pipeline with each item
    typedef struct packed {
        logic negate;
        logic zero_div;
        logic ovf;
    } div_tag_t;

endpackage

/* rtl/signed_integer_divider_top.sv */
// pipelined signed integer divider, quotient truncated toward zero
`timescale 1ns / 1ps

// Signed integer divider. A division is taken on every rising edge where start
// is high and busy is low; busy stays low, so a new division may be issued in
// every cycle. Each result appears on result for one cycle with done high,
// after the division has passed through the pipeline: one stage forms the
// operand magnitudes, DIV_WIDTH stages each resolve one quotient bit with a
// single subtract and compare, and one stage restores the sign and
// applies the special cases. The receiver cannot hold results off, so it must
// take done whenever it shows. A zero divisor gives -1 with zero_divisor set;
// the most negative value divided by -1 gives the largest positive value with
// overflowed set.
module signed_integer_divider_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sid_pkg::div_in_t operands,
    output logic             done,
    output sid_pkg::div_out_t result
);

    import sid_pkg::*;

    localparam int W = DIV_WIDTH;

    // pipeline registers, index 0 holds magnitudes, index W the unsigned quotient magnitude
    logic             valid_reg [W+1];
    logic [W-1:0]     rem_reg   [W+1];
    logic [W-1:0]     quo_reg   [W+1];
    logic [W-1:0]     dvs_reg   [W+1];
    div_tag_t         tag_reg   [W+1];

    logic             valid_next [W+1];
    logic [W-1:0]     rem_next   [W+1];
    logic [W-1:0]     quo_next   [W+1];
    logic [W-1:0]     dvs_next   [W+1];
    div_tag_t         tag_next   [W+1];

    logic             done_reg;
    logic             done_next;
    div_out_t         result_reg;
    div_out_t         result_next;

    logic             accept;
    logic [W-1:0]     num_u;
    logic [W-1:0]     den_u;
    logic             num_neg;
    logic             den_neg;
    logic [W:0]       trial [W];
    logic [W-1:0]     q_mag;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // input stage and the quotient stages
    always_comb
    begin
        // magnitudes and special cases
        num_u   = operands.numerator;
        den_u   = operands.denominator;
        num_neg = num_u[W-1];
        den_neg = den_u[W-1];

        valid_next[0]        = accept;
        rem_next[0]          = '0;
        quo_next[0]          = num_neg ? (~num_u + 1'b1) : num_u;
        dvs_next[0]          = den_neg ? (~den_u + 1'b1) : den_u;
        tag_next[0].negate   = num_neg ^ den_neg;
        tag_next[0].zero_div = (den_u == '0);
        tag_next[0].ovf      = (num_u == DIV_MOST_NEG) && (den_u == DIV_ALL_ONES);

        // one restoring step per stage: shift in a dividend bit, try the subtract
        for (int k = 0; k < W; k++) begin
            trial[k] = {rem_reg[k], quo_reg[k][W-1]} - {1'b0, dvs_reg[k]};
            if (!trial[k][W]) begin
                rem_next[k+1] = trial[k][W-1:0];
                quo_next[k+1] = {quo_reg[k][W-2:0], 1'b1};
            end
            else begin
                rem_next[k+1] = {rem_reg[k][W-2:0], quo_reg[k][W-1]};
                quo_next[k+1] = {quo_reg[k][W-2:0], 1'b0};
            end
            valid_next[k+1] = valid_reg[k];
            dvs_next[k+1]   = dvs_reg[k];
            tag_next[k+1]   = tag_reg[k];
        end
    end

    // output stage: sign restore and special cases
    always_comb
    begin
        q_mag       = quo_reg[W];
        done_next   = valid_reg[W];
        result_next.zero_divisor = tag_reg[W].zero_div;
        result_next.overflowed   = tag_reg[W].ovf && !tag_reg[W].zero_div;
        if (tag_reg[W].zero_div) begin
            result_next.quotient = DIV_ALL_ONES;
        end
        else if (tag_reg[W].ovf) begin
            result_next.quotient = DIV_MOST_POS;
        end
        else if (tag_reg[W].negate) begin
            result_next.quotient = ~q_mag + 1'b1;
        end
        else begin
            result_next.quotient = q_mag;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= W; k++) begin
                valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else begin
            for (int k = 0; k <= W; k++) begin
                valid_reg[k] <= valid_next[k];
            end
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= W; k++) begin
            rem_reg[k] <= rem_next[k];
            quo_reg[k] <= quo_next[k];
            dvs_reg[k] <= dvs_next[k];
            tag_reg[k] <= tag_next[k];
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/sid_checker.sv */
// port-level checker for the signed integer divider and its bind
`timescale 1ns / 1ps

module sid_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sid_pkg::div_in_t  operands,
    input logic              done,
    input sid_pkg::div_out_t result
);

    import sid_pkg::*;

    // every transfer in produces a result after the fixed latency
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##DIV_LATENCY done)
    else $error("accepted division produced no result");

    // no result without a matching transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, DIV_LATENCY))
    else $error("result without a matching request");

    // zero divisor flag follows the divisor of the matching request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.zero_divisor == $past(operands.denominator == '0, DIV_LATENCY)))
    else $error("zero divisor flag does not match request");

    // zero divisor gives all ones and never the overflow flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.zero_divisor) |->
            (result.quotient == DIV_ALL_ONES) && !result.overflowed)
    else $error("bad zero divisor result");

    // overflow saturates to the largest positive value
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflowed) |-> (result.quotient == DIV_MOST_POS))
    else $error("overflow not saturated");

endmodule

bind signed_integer_divider_top sid_checker u_sid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
);
